// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define SEGX_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define SEGX_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/segx_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection package
// Stage counts and the flag group shared by the pipeline modules.
// ----------------------------------------------------------------------------
package segx_pkg;

   // Register stages ahead of and behind the divider pipelines.
   localparam int FRONT_STAGES = 4;
   localparam int BACK_STAGES  = 2;

   // Sign and degeneracy flags carried along with each item.
   typedef struct packed {
      logic neg_a;
      logic neg_b;
      logic den_zero;
   } segx_flags_type;

endpackage

// ===== sv/segx_if.sv =====
// ----------------------------------------------------------------------------
// Segment intersection channels
// Valid/ready channels for segment pairs and for crossing results.
// ----------------------------------------------------------------------------
interface segx_req_if #(
   parameter int CW = 16
);
   logic          valid;
   logic          ready;
   logic signed [CW-1:0] seg_a_start_x;
   logic signed [CW-1:0] seg_a_start_y;
   logic signed [CW-1:0] seg_a_end_x;
   logic signed [CW-1:0] seg_a_end_y;
   logic signed [CW-1:0] seg_b_start_x;
   logic signed [CW-1:0] seg_b_start_y;
   logic signed [CW-1:0] seg_b_end_x;
   logic signed [CW-1:0] seg_b_end_y;

   modport source (
      output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
             seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
      input  ready
   );
   modport sink (
      input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
             seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
      output ready
   );
endinterface

interface segx_rsp_if #(
   parameter int CW = 16
);
   logic          valid;
   logic          ready;
   logic          hit;
   logic signed [CW-1:0] cross_x;
   logic signed [CW-1:0] cross_y;

   modport source (output valid, hit, cross_x, cross_y, input ready);
   modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

// ===== sv/segx_front.sv =====
// ----------------------------------------------------------------------------
// Segment intersection front end
// Four stages: direction vectors, cross products, Cramer terms, magnitudes.
// ----------------------------------------------------------------------------
module segx_front #(
   parameter int CW = 16,
   localparam int D = CW + 1,
   localparam int P = 2 * D,
   localparam int N = P + 1
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [CW-1:0]   a0x,
   input  logic signed [CW-1:0]   a0y,
   input  logic signed [CW-1:0]   a1x,
   input  logic signed [CW-1:0]   a1y,
   input  logic signed [CW-1:0]   b0x,
   input  logic signed [CW-1:0]   b0y,
   input  logic signed [CW-1:0]   b1x,
   input  logic signed [CW-1:0]   b1y,
   output logic [N-1:0]           den_mag,
   output logic [N-1:0]           na_mag,
   output logic [N-1:0]           nb_mag,
   output segx_pkg::segx_flags_type flags,
   output logic signed [CW-1:0]   base_x,
   output logic signed [CW-1:0]   base_y,
   output logic signed [D-1:0]    dir_x,
   output logic signed [D-1:0]    dir_y
);

   // Stage 1: direction and offset vectors.
   logic signed [D-1:0] dax_ff, day_ff, dbx_ff, dby_ff, ox_ff, oy_ff;
   logic signed [CW-1:0] a0x_1_ff, a0y_1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dax_ff   <= D'(a1x) - D'(a0x);
         day_ff   <= D'(a1y) - D'(a0y);
         dbx_ff   <= D'(b1x) - D'(b0x);
         dby_ff   <= D'(b1y) - D'(b0y);
         ox_ff    <= D'(a0x) - D'(b0x);
         oy_ff    <= D'(a0y) - D'(b0y);
         a0x_1_ff <= a0x;
         a0y_1_ff <= a0y;
      end
   end

   // Stage 2: the six cross-product terms.
   logic signed [P-1:0] pd0_ff, pd1_ff, pb0_ff, pb1_ff, pa0_ff, pa1_ff;
   logic signed [CW-1:0] a0x_2_ff, a0y_2_ff;
   logic signed [D-1:0] dax_2_ff, day_2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pd0_ff   <= P'(dax_ff) * P'(dby_ff);
         pd1_ff   <= P'(dbx_ff) * P'(day_ff);
         pb0_ff   <= P'(dax_ff) * P'(oy_ff);
         pb1_ff   <= P'(day_ff) * P'(ox_ff);
         pa0_ff   <= P'(dbx_ff) * P'(oy_ff);
         pa1_ff   <= P'(dby_ff) * P'(ox_ff);
         a0x_2_ff <= a0x_1_ff;
         a0y_2_ff <= a0y_1_ff;
         dax_2_ff <= dax_ff;
         day_2_ff <= day_ff;
      end
   end

   // Stage 3: denominator and the two numerators.
   logic signed [N-1:0] den_ff, na_ff, nb_ff;
   logic signed [CW-1:0] a0x_3_ff, a0y_3_ff;
   logic signed [D-1:0] dax_3_ff, day_3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff   <= N'(pd0_ff) - N'(pd1_ff);
         nb_ff    <= N'(pb0_ff) - N'(pb1_ff);
         na_ff    <= N'(pa0_ff) - N'(pa1_ff);
         a0x_3_ff <= a0x_2_ff;
         a0y_3_ff <= a0y_2_ff;
         dax_3_ff <= dax_2_ff;
         day_3_ff <= day_2_ff;
      end
   end

   // Stage 4: magnitudes, quotient signs and the zero-denominator flag.
   logic [N-1:0] den_mag_ff, na_mag_ff, nb_mag_ff;
   segx_pkg::segx_flags_type flags_ff;
   logic signed [CW-1:0] a0x_4_ff, a0y_4_ff;
   logic signed [D-1:0] dax_4_ff, day_4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den_mag_ff        <= den_ff[N-1] ? N'(-den_ff) : N'(den_ff);
         na_mag_ff         <= na_ff[N-1] ? N'(-na_ff) : N'(na_ff);
         nb_mag_ff         <= nb_ff[N-1] ? N'(-nb_ff) : N'(nb_ff);
         flags_ff.neg_a    <= na_ff[N-1] ^ den_ff[N-1];
         flags_ff.neg_b    <= nb_ff[N-1] ^ den_ff[N-1];
         flags_ff.den_zero <= (den_ff == '0);
         a0x_4_ff          <= a0x_3_ff;
         a0y_4_ff          <= a0y_3_ff;
         dax_4_ff          <= dax_3_ff;
         day_4_ff          <= day_3_ff;
      end
   end

   assign den_mag = den_mag_ff;
   assign na_mag  = na_mag_ff;
   assign nb_mag  = nb_mag_ff;
   assign flags   = flags_ff;
   assign base_x  = a0x_4_ff;
   assign base_y  = a0y_4_ff;
   assign dir_x   = dax_4_ff;
   assign dir_y   = day_4_ff;

endmodule

// ===== sv/segx_div.sv =====
// ----------------------------------------------------------------------------
// Segment intersection divider
// Restoring divider pipeline, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module segx_div #(
   parameter int NW = 35,
   parameter int F  = 16,
   localparam int RW = NW + 1,
   localparam int QW = F + 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic [QW-1:0] quo,
   output logic          ovf
);

   logic [RW-1:0] rem_ff [QW];
   logic [NW-1:0] dv_ff  [QW];
   logic [QW-1:0] q_ff   [QW];
   logic          ovf_ff [QW];

   // First stage: flag a quotient of two or more, then take the integer bit.
   logic [RW-1:0] rem0;
   logic          ge0;

   always_comb begin
      rem0 = RW'(num);
      ge0  = rem0 >= RW'(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= rem0 >= {den, 1'b0};
         rem_ff[0] <= ge0 ? rem0 - RW'(den) : rem0;
         q_ff[0]   <= QW'(ge0);
         dv_ff[0]  <= den;
      end
   end

   // Later stages: one fraction bit each.
   for (genvar k = 1; k < QW; k++) begin : g_step
      logic [RW-1:0] sh;
      logic          ge;

      always_comb begin
         sh = {rem_ff[k-1][RW-2:0], 1'b0};
         ge = sh >= RW'(dv_ff[k-1]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? sh - RW'(dv_ff[k-1]) : sh;
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
            dv_ff[k]  <= dv_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = q_ff[QW-1];
   assign ovf = ovf_ff[QW-1];

endmodule

// ===== sv/segx_back.sv =====
// ----------------------------------------------------------------------------
// Segment intersection back end
// Range test of both parameters, offset multiply and crossing point.
// ----------------------------------------------------------------------------
module segx_back #(
   parameter int CW = 16,
   parameter int F  = 16,
   localparam int D  = CW + 1,
   localparam int QW = F + 1,
   localparam int MW = QW + D
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [QW-1:0]            qa,
   input  logic                     ovfa,
   input  logic [QW-1:0]            qb,
   input  logic                     ovfb,
   input  segx_pkg::segx_flags_type flags,
   input  logic signed [CW-1:0]     base_x,
   input  logic signed [CW-1:0]     base_y,
   input  logic signed [D-1:0]      dir_x,
   input  logic signed [D-1:0]      dir_y,
   output logic                     hit,
   output logic signed [CW-1:0]     cross_x,
   output logic signed [CW-1:0]     cross_y
);

   localparam logic [QW-1:0] Q_ONE = {1'b1, {F{1'b0}}};

   // Stage 1: both parameters in [0,1], and the scaled offsets along A.
   logic          pass_in;
   logic [D-1:0]  mag_x, mag_y;
   logic          pass_ff, sx_ff, sy_ff;
   logic [MW-1:0] prod_x_ff, prod_y_ff;
   logic signed [CW-1:0] bx_ff, by_ff;

   always_comb begin
      pass_in = !flags.den_zero && !ovfa && !ovfb && (qa <= Q_ONE) && (qb <= Q_ONE)
                && (!flags.neg_a || qa == '0) && (!flags.neg_b || qb == '0);
      mag_x   = dir_x[D-1] ? D'(-dir_x) : D'(dir_x);
      mag_y   = dir_y[D-1] ? D'(-dir_y) : D'(dir_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass_ff   <= pass_in;
         prod_x_ff <= MW'(qa) * MW'(mag_x);
         prod_y_ff <= MW'(qa) * MW'(mag_y);
         sx_ff     <= dir_x[D-1];
         sy_ff     <= dir_y[D-1];
         bx_ff     <= base_x;
         by_ff     <= base_y;
      end
   end

   // Stage 2: signed offset added to the start of A, zero without a hit.
   logic [D:0] off_x, off_y, sum_x, sum_y;
   logic       hit_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;

   always_comb begin
      off_x = {1'b0, prod_x_ff[F +: D]};
      off_y = {1'b0, prod_y_ff[F +: D]};
      sum_x = (D+1)'(bx_ff) + (sx_ff ? -off_x : off_x);
      sum_y = (D+1)'(by_ff) + (sy_ff ? -off_y : off_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= pass_ff;
         cx_ff  <= pass_ff ? sum_x[CW-1:0] : '0;
         cy_ff  <= pass_ff ? sum_y[CW-1:0] : '0;
      end
   end

   assign hit     = hit_ff;
   assign cross_x = cx_ff;
   assign cross_y = cy_ff;

endmodule

// ===== sv/segment_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// Segment intersection 2D
// Crossing test of two segments with a pipelined Cramer's rule solver.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents
//  req_bus  in   two segments, start and end points, signed Q12.4
//  rsp_bus  out  hit flag and crossing point, signed Q12.4
//
//  One segment pair is taken every cycle while the skid register is empty;
//  each pair passes the front end, the two divider pipelines that resolve
//  one quotient bit per stage, the back end and the output register.
//  Reset (synchronous) clears the stage valid bits and the output buffer.
//  A stalled result is held at the output while a skid register takes one
//  more; the pipeline then halts as a whole without loss.
// ----------------------------------------------------------------------------
module segment_intersection_2d #(
   parameter int COORD_BITS      = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   segx_req_if.sink   req_bus,
   segx_rsp_if.source rsp_bus
);

   localparam int CW = COORD_BITS;
   localparam int F  = PARAM_FRAC_BITS;
   localparam int D  = CW + 1;
   localparam int N  = 2 * D + 1;
   localparam int QW = F + 1;
   localparam int S  = segx_pkg::FRONT_STAGES + QW + segx_pkg::BACK_STAGES;

   logic en;
   logic skid_v_ff;

   // Stage valid bits advance with the whole pipeline.
   logic [S-1:0] v_ff;

   assign en            = !skid_v_ff;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[S-2:0], req_bus.valid};
      end
   end

   // Front end.
   logic [N-1:0] den_mag, na_mag, nb_mag;
   segx_pkg::segx_flags_type flags;
   logic signed [CW-1:0] base_x, base_y;
   logic signed [D-1:0] dir_x, dir_y;

   segx_front #(.CW(CW)) u_front (
      .clock   (clock),
      .en      (en),
      .a0x     (req_bus.seg_a_start_x),
      .a0y     (req_bus.seg_a_start_y),
      .a1x     (req_bus.seg_a_end_x),
      .a1y     (req_bus.seg_a_end_y),
      .b0x     (req_bus.seg_b_start_x),
      .b0y     (req_bus.seg_b_start_y),
      .b1x     (req_bus.seg_b_end_x),
      .b1y     (req_bus.seg_b_end_y),
      .den_mag (den_mag),
      .na_mag  (na_mag),
      .nb_mag  (nb_mag),
      .flags   (flags),
      .base_x  (base_x),
      .base_y  (base_y),
      .dir_x   (dir_x),
      .dir_y   (dir_y)
   );

   // Two dividers, one per segment parameter.
   logic [QW-1:0] qa, qb;
   logic          ovfa, ovfb;

   segx_div #(.NW(N), .F(F)) u_div_a (
      .clock (clock), .en (en), .num (na_mag), .den (den_mag), .quo (qa), .ovf (ovfa)
   );

   segx_div #(.NW(N), .F(F)) u_div_b (
      .clock (clock), .en (en), .num (nb_mag), .den (den_mag), .quo (qb), .ovf (ovfb)
   );

   // Side data delayed to line up with the quotients.
   segx_pkg::segx_flags_type flags_ff [QW];
   logic signed [CW-1:0] bx_ff [QW];
   logic signed [CW-1:0] by_ff [QW];
   logic signed [D-1:0]  dx_ff [QW];
   logic signed [D-1:0]  dy_ff [QW];

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff[0] <= flags;
         bx_ff[0]    <= base_x;
         by_ff[0]    <= base_y;
         dx_ff[0]    <= dir_x;
         dy_ff[0]    <= dir_y;
         for (int i = 1; i < QW; i++) begin
            flags_ff[i] <= flags_ff[i-1];
            bx_ff[i]    <= bx_ff[i-1];
            by_ff[i]    <= by_ff[i-1];
            dx_ff[i]    <= dx_ff[i-1];
            dy_ff[i]    <= dy_ff[i-1];
         end
      end
   end

   // Back end.
   logic                 up_hit;
   logic signed [CW-1:0] up_x, up_y;

   segx_back #(.CW(CW), .F(F)) u_back (
      .clock   (clock),
      .en      (en),
      .qa      (qa),
      .ovfa    (ovfa),
      .qb      (qb),
      .ovfb    (ovfb),
      .flags   (flags_ff[QW-1]),
      .base_x  (bx_ff[QW-1]),
      .base_y  (by_ff[QW-1]),
      .dir_x   (dx_ff[QW-1]),
      .dir_y   (dy_ff[QW-1]),
      .hit     (up_hit),
      .cross_x (up_x),
      .cross_y (up_y)
   );

   // Output register with one skid entry.
   logic                 out_v_ff, out_hit_ff, skid_hit_ff;
   logic signed [CW-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (en) begin
         if (out_v_ff && !rsp_bus.ready) begin
            skid_v_ff <= v_ff[S-1];
         end else begin
            out_v_ff <= v_ff[S-1];
         end
      end else if (rsp_bus.ready) begin
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (out_v_ff && !rsp_bus.ready) begin
            skid_hit_ff <= up_hit;
            skid_x_ff   <= up_x;
            skid_y_ff   <= up_y;
         end else begin
            out_hit_ff <= up_hit;
            out_x_ff   <= up_x;
            out_y_ff   <= up_y;
         end
      end else if (rsp_bus.ready) begin
         out_hit_ff <= skid_hit_ff;
         out_x_ff   <= skid_x_ff;
         out_y_ff   <= skid_y_ff;
      end
   end

   assign rsp_bus.valid   = out_v_ff;
   assign rsp_bus.hit     = out_hit_ff;
   assign rsp_bus.cross_x = out_x_ff;
   assign rsp_bus.cross_y = out_y_ff;

endmodule

// ===== sv/segx_checker.sv =====
// ----------------------------------------------------------------------------
// Segment intersection checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segx_checker #(
   parameter int CW = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic signed [CW-1:0] rsp_cross_x,
   input logic signed [CW-1:0] rsp_cross_y
);

   // A result that is refused stays offered.
   `SEGX_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // A result without a hit carries a zero point.
   `SEGX_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_hit |-> rsp_cross_x == '0 && rsp_cross_y == '0, "nonzero point without hit")

   // Input stalls only while a result waits at the output.
   `SEGX_ASSERT(a_stall_cause, clock, reset, !req_ready |-> rsp_valid, "input stalled with empty output")

   // Reset empties the output.
   `SEGX_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result offered after reset")

endmodule

bind segment_intersection_2d segx_checker #(.CW(COORD_BITS)) u_segx_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_hit     (rsp_bus.hit),
   .rsp_cross_x (rsp_bus.cross_x),
   .rsp_cross_y (rsp_bus.cross_y)
);
